### hdl/cart_pkg.sv
// cart_pkg: widths, codes, reset values and shared types of the chunk ack tracker
// used by the channel interfaces, the compare/subtract unit and the top level
// no dependencies
package cart_pkg;

    localparam int SLOTS     = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int TOT_W     = 23;
    localparam int CS_W      = 16;
    localparam int MS_W      = 8;
    localparam int RC_W      = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 23;
    localparam int ALU_W     = 24;

    // opcodes
    localparam logic [OP_W-1:0] OP_ACK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SENT = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_LIMIT = 2'd2;

    // reset values
    localparam logic [TOT_W-1:0] RST_TOTAL_SIZE = 23'd0;
    localparam logic [CS_W-1:0]  RST_CHUNK_SIZE = 16'd1024;
    localparam logic [MS_W-1:0]  RST_SEND_LIMIT = 8'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_EXEC = 5'b00100,
        S_EMIT = 5'b01000,
        S_SCAN = 5'b10000
    } t_state;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } t_alu_rsp;

endpackage

### hdl/cart_if.sv
// cart_if: item channels of the chunk ack tracker, request and result
// depends on cart_pkg for field widths
interface cart_req_if;
    logic                         valid;
    logic                         ready;
    logic [cart_pkg::OP_W-1:0]    opcode;
    logic [cart_pkg::IDX_W-1:0]   chunk_index;

    modport source (output valid, opcode, chunk_index, input ready);
    modport sink   (input valid, opcode, chunk_index, output ready);
endinterface

interface cart_res_if;
    logic                         valid;
    logic                         ready;
    logic [cart_pkg::IDX_W-1:0]   listed_chunk;
    logic                         last;
    logic                         listing;
    logic                         all_acked;
    logic                         send_failed;

    modport source (output valid, listed_chunk, last, listing, all_acked, send_failed,
                    input ready);
    modport sink   (input valid, listed_chunk, last, listing, all_acked, send_failed,
                    output ready);
endinterface

### hdl/cart_alu.sv
// cart_alu: shared compare/subtract unit, a >= b and a - b
// depends on cart_pkg for the request and response structs
module cart_alu (
    input  cart_pkg::t_alu_req i_req,
    output cart_pkg::t_alu_rsp o_rsp
);
    logic [cart_pkg::ALU_W:0] w_sub;

    assign w_sub      = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.ge   = ~w_sub[cart_pkg::ALU_W];
    assign o_rsp.diff = w_sub[cart_pkg::ALU_W-1:0];
endmodule

### hdl/chunk_ack_retry_tracker.sv
// chunk_ack_retry_tracker: selective-repeat ack tracker for a chunked transfer
// depends on cart_pkg, cart_if (cart_req_if, cart_res_if) and cart_alu
//
// usage
// - i_req carries one item: opcode (ack, sent, scan) and chunk_index
// - o_res carries result items: listed_chunk, last, listing, all_acked, send_failed
// - config port: i_cfg_we / i_cfg_idx / i_cfg_wdata, one register per write, no wait
// - a write of total_size or chunk_size recomputes the chunk count with a restoring
//   division on the shared compare/subtract unit: one quotient bit a cycle;
//   i_req.ready stays low meanwhile; a capped write sets failed and the count to the cap
// - the cap check (total > MAX_CHUNKS * chunk_size) is done at the write itself
// per item
// - ack, sent and unused opcode: one result, taken through accept, execute on the
//   shared unit and load of the output register before the next item is let in
// - scan: one chunk number checked per cycle by the shared unit while the receiver
//   does not stall a listed chunk (an empty scan walks the whole count, then loads
//   one plain result); last marks the final unacked chunk
// - the output register lets the next item in while the last result still waits
// reset: maps cleared, chunk count 0, failed flag clear, registers at their defaults
// receiver stall: the result holds in the output register, a scan pauses on it
module chunk_ack_retry_tracker #(
    parameter int MAX_CHUNKS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cart_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cart_pkg::CFG_W-1:0]       i_cfg_wdata,
    cart_req_if.sink                         i_req,
    cart_res_if.source                       o_res
);
    // quotient bits needed for a count up to MAX_CHUNKS
    localparam int QW = $clog2(MAX_CHUNKS + 1);
    localparam int KW = (QW > 1) ? $clog2(QW) : 1;
    localparam logic [KW-1:0]                K_TOP = KW'(QW - 1);
    localparam logic [cart_pkg::CNT_W-1:0]   CAP   = cart_pkg::CNT_W'(MAX_CHUNKS);
    localparam logic [cart_pkg::ALU_W-1:0]   CAP_W = cart_pkg::ALU_W'(MAX_CHUNKS);

    // configuration
    logic [cart_pkg::TOT_W-1:0]  r_total, n_total;
    logic [cart_pkg::CS_W-1:0]   r_cs, n_cs;
    logic [cart_pkg::MS_W-1:0]   r_max, n_max;

    // transfer state
    logic [cart_pkg::CNT_W-1:0]  r_ct, n_ct;
    logic                        r_failed, n_failed;
    logic [cart_pkg::SLOTS-1:0]  r_acked, n_acked;
    logic [cart_pkg::SLOTS-1:0]  r_sent, n_sent;
    logic [cart_pkg::RC_W-1:0]   r_cnt_mem [cart_pkg::SLOTS];
    logic [cart_pkg::RC_W-1:0]   r_cnt_rd;

    // sequencer
    cart_pkg::t_state            r_state, n_state;
    logic [cart_pkg::OP_W-1:0]   r_op, n_op;
    logic [cart_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [cart_pkg::TOT_W-1:0]  r_rem, n_rem;
    logic [QW-1:0]               r_q, n_q;
    logic [KW-1:0]               r_k, n_k;
    logic [cart_pkg::CNT_W-1:0]  r_i, n_i;

    // output register
    logic                        r_ov, n_ov;
    logic [cart_pkg::IDX_W-1:0]  r_out_chunk;
    logic                        r_out_last;
    logic                        r_out_listing;
    logic                        r_out_all;
    logic                        r_out_failed;

    // shared unit
    cart_pkg::t_alu_req          w_alu_req;
    cart_pkg::t_alu_rsp          w_alu_rsp;

    logic                        w_accept;
    logic                        w_slot_free;
    logic [cart_pkg::SLOTS-1:0]  w_below;
    logic [cart_pkg::SLOTS-1:0]  w_unacked;
    logic                        w_all_acked;
    logic                        w_more;
    logic [cart_pkg::CS_W-1:0]   w_cs_eff;
    logic [cart_pkg::RC_W-1:0]   w_new_cnt;
    logic                        w_cnt_we;
    logic [QW-1:0]               w_q_step;
    logic [cart_pkg::TOT_W-1:0]  w_rem_step;
    logic [cart_pkg::TOT_W-1:0]  w_cfg_total;
    logic [cart_pkg::CS_W-1:0]   w_cfg_cs;
    logic [cart_pkg::CS_W-1:0]   w_cfg_cs_eff;
    logic                        w_cfg_capped;
    logic                        w_cfg_size_wr;
    logic                        w_out_load;
    logic [cart_pkg::IDX_W-1:0]  w_out_chunk;
    logic                        w_out_last;
    logic                        w_out_listing;

    cart_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign i_req.ready  = (r_state == cart_pkg::S_IDLE) && !i_cfg_we;
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_slot_free  = !r_ov || o_res.ready;
    assign w_cs_eff     = (r_cs == '0) ? cart_pkg::CS_W'(1) : r_cs;

    // chunks below the chunk count, and which of them still lack an ack
    always_comb begin
        for (int j = 0; j < cart_pkg::SLOTS; j++) begin
            w_below[j] = (cart_pkg::CNT_W'(j) < r_ct);
        end
    end
    assign w_unacked   = w_below & ~r_acked;
    assign w_all_acked = ~|w_unacked;
    // any unacked chunk above the scan position
    assign w_more      = |(w_unacked >> (r_i + cart_pkg::CNT_W'(1)));

    // resend count update, saturating
    assign w_new_cnt = !r_sent[r_idx] ? '0 :
                       (r_cnt_rd == '1) ? r_cnt_rd : r_cnt_rd + cart_pkg::RC_W'(1);

    // one division step
    assign w_q_step   = w_alu_rsp.ge ? (r_q | (QW'(1) << r_k)) : r_q;
    assign w_rem_step = w_alu_rsp.ge ? w_alu_rsp.diff[cart_pkg::TOT_W-1:0] : r_rem;

    // cap check straight from the write data
    always_comb begin
        w_cfg_total   = r_total;
        w_cfg_cs      = r_cs;
        w_cfg_size_wr = 1'b0;
        if (i_cfg_we && i_cfg_idx == cart_pkg::REG_TOTAL_SIZE) begin
            w_cfg_total   = i_cfg_wdata[cart_pkg::TOT_W-1:0];
            w_cfg_size_wr = 1'b1;
        end
        if (i_cfg_we && i_cfg_idx == cart_pkg::REG_CHUNK_SIZE) begin
            w_cfg_cs      = i_cfg_wdata[cart_pkg::CS_W-1:0];
            w_cfg_size_wr = 1'b1;
        end
    end
    assign w_cfg_cs_eff = (w_cfg_cs == '0) ? cart_pkg::CS_W'(1) : w_cfg_cs;
    assign w_cfg_capped = cart_pkg::ALU_W'(w_cfg_total) > (cart_pkg::ALU_W'(w_cfg_cs_eff) * CAP_W);

    // shared unit operands by sequencer state
    always_comb begin
        w_alu_req.a = '0;
        w_alu_req.b = '0;
        case (r_state)
            cart_pkg::S_DIV: begin
                w_alu_req.a = cart_pkg::ALU_W'(r_rem);
                w_alu_req.b = cart_pkg::ALU_W'(w_cs_eff) << r_k;
            end
            cart_pkg::S_EXEC: begin
                if (r_op == cart_pkg::OP_SENT) begin
                    w_alu_req.a = cart_pkg::ALU_W'(r_max);
                    w_alu_req.b = cart_pkg::ALU_W'(w_new_cnt);
                end else begin
                    w_alu_req.a = cart_pkg::ALU_W'(r_idx);
                    w_alu_req.b = cart_pkg::ALU_W'(r_ct);
                end
            end
            cart_pkg::S_SCAN: begin
                w_alu_req.a = cart_pkg::ALU_W'(r_i);
                w_alu_req.b = cart_pkg::ALU_W'(r_ct);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_total       = w_cfg_total;
        n_cs          = w_cfg_cs;
        n_max         = r_max;
        n_ct          = r_ct;
        n_failed      = r_failed;
        n_acked       = r_acked;
        n_sent        = r_sent;
        n_state       = r_state;
        n_op          = r_op;
        n_idx         = r_idx;
        n_rem         = r_rem;
        n_q           = r_q;
        n_k           = r_k;
        n_i           = r_i;
        w_cnt_we      = 1'b0;
        w_out_load    = 1'b0;
        w_out_chunk   = '0;
        w_out_last    = 1'b1;
        w_out_listing = 1'b0;

        case (r_state)
            cart_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_req.opcode;
                    n_idx   = i_req.chunk_index;
                    n_i     = '0;
                    n_state = (i_req.opcode == cart_pkg::OP_SCAN) ? cart_pkg::S_SCAN
                                                                  : cart_pkg::S_EXEC;
                end
            end
            cart_pkg::S_DIV: begin
                n_rem = w_rem_step;
                n_q   = w_q_step;
                if (r_k == '0) begin
                    // round up when a remainder is left
                    n_ct    = cart_pkg::CNT_W'(w_q_step)
                            + cart_pkg::CNT_W'(w_rem_step != '0);
                    n_state = cart_pkg::S_IDLE;
                end else begin
                    n_k = r_k - KW'(1);
                end
            end
            cart_pkg::S_EXEC: begin
                case (r_op)
                    cart_pkg::OP_ACK: begin
                        // out of range acks are dropped
                        if (!w_alu_rsp.ge) begin
                            n_acked[r_idx] = 1'b1;
                        end
                    end
                    cart_pkg::OP_SENT: begin
                        n_sent[r_idx] = 1'b1;
                        w_cnt_we      = 1'b1;
                        if (!w_alu_rsp.ge) begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = cart_pkg::S_EMIT;
            end
            cart_pkg::S_EMIT: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_state    = cart_pkg::S_IDLE;
                end
            end
            cart_pkg::S_SCAN: begin
                if (w_alu_rsp.ge) begin
                    // walked off the end without an unacked chunk
                    n_state = cart_pkg::S_EMIT;
                end else if (r_acked[r_i[cart_pkg::IDX_W-1:0]]) begin
                    n_i = r_i + cart_pkg::CNT_W'(1);
                end else if (w_slot_free) begin
                    w_out_load    = 1'b1;
                    w_out_chunk   = r_i[cart_pkg::IDX_W-1:0];
                    w_out_last    = !w_more;
                    w_out_listing = 1'b1;
                    n_i           = r_i + cart_pkg::CNT_W'(1);
                    if (!w_more) begin
                        n_state = cart_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = cart_pkg::S_IDLE;
            end
        endcase

        // register writes, to be made only while idle; the block itself does not enforce this
        if (i_cfg_we && i_cfg_idx == cart_pkg::REG_SEND_LIMIT) begin
            n_max = i_cfg_wdata[cart_pkg::MS_W-1:0];
        end
        if (w_cfg_size_wr) begin
            if (w_cfg_capped) begin
                n_failed = 1'b1;
                n_ct     = CAP;
                n_state  = cart_pkg::S_IDLE;
            end else begin
                n_rem   = w_cfg_total;
                n_q     = '0;
                n_k     = K_TOP;
                n_state = cart_pkg::S_DIV;
            end
        end

        n_ov = w_out_load ? 1'b1 : (r_ov && !o_res.ready ? 1'b1 : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= cart_pkg::RST_TOTAL_SIZE;
            r_cs     <= cart_pkg::RST_CHUNK_SIZE;
            r_max    <= cart_pkg::RST_SEND_LIMIT;
            r_ct     <= '0;
            r_failed <= 1'b0;
            r_acked  <= '0;
            r_sent   <= '0;
            r_state  <= cart_pkg::S_IDLE;
            r_ov     <= 1'b0;
        end else begin
            r_total  <= n_total;
            r_cs     <= n_cs;
            r_max    <= n_max;
            r_ct     <= n_ct;
            r_failed <= n_failed;
            r_acked  <= n_acked;
            r_sent   <= n_sent;
            r_state  <= n_state;
            r_ov     <= n_ov;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_idx <= n_idx;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_k   <= n_k;
        r_i   <= n_i;
        if (w_out_load) begin
            r_out_chunk   <= w_out_chunk;
            r_out_last    <= w_out_last;
            r_out_listing <= w_out_listing;
            r_out_all     <= w_all_acked;
            r_out_failed  <= r_failed;
        end
    end

    // resend counts, read at the accept edge, written in the execute cycle
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[r_idx] <= w_new_cnt;
        end
        r_cnt_rd <= r_cnt_mem[i_req.chunk_index];
    end

    assign o_res.valid        = r_ov;
    assign o_res.listed_chunk = r_out_chunk;
    assign o_res.last         = r_out_last;
    assign o_res.listing      = r_out_listing;
    assign o_res.all_acked    = r_out_all;
    assign o_res.send_failed  = r_out_failed;

endmodule

### hdl/cart_chk.sv
// cart_chk: port-level checks of the chunk ack tracker, bound to the top level
// depends on chunk_ack_retry_tracker and its cart_if channels
module cart_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cart_pkg::IDX_W-1:0]     i_listed_chunk,
    input logic                           i_last,
    input logic                           i_listing,
    input logic                           i_send_failed
);
    // nothing presented right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a result without a listed chunk closes its item and carries chunk zero
    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_listing |-> i_last && i_listed_chunk == '0)
        else $error("non-listing result not last or chunk not zero");

    // no new item taken while a scan still has chunks to list
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_listing && !i_last |-> !(i_in_valid && i_in_ready))
        else $error("item accepted in the middle of a scan");

    // failed flag never clears between back-to-back results
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_send_failed |=> !i_out_valid || i_send_failed)
        else $error("send_failed dropped");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_listed_chunk)
            && $stable(i_last) && $stable(i_listing))
        else $error("stalled result changed");
endmodule

bind chunk_ack_retry_tracker cart_chk u_cart_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_listed_chunk (o_res.listed_chunk),
    .i_last         (o_res.last),
    .i_listing      (o_res.listing),
    .i_send_failed  (o_res.send_failed)
);
